>>> design/dxpu_pkg.sv
`default_nettype none
package dxpu_pkg;

   // default build values
   localparam int VALUE_BITS_DEF   = 32;
   localparam int FRAC_BITS_DEF    = 8;
   localparam int SYMBOL_BYTES_DEF = 8;

   // configuration register indexes
   localparam logic [1:0] CSR_ACTIVE  = 2'd0;
   localparam logic [1:0] CSR_PDI_SEL = 2'd1;
   localparam logic [1:0] CSR_MDI_SEL = 2'd2;

   // held side codes
   localparam logic [1:0] SIDE_NONE  = 2'd0;
   localparam logic [1:0] SIDE_PLUS  = 2'd1;
   localparam logic [1:0] SIDE_MINUS = 2'd2;

   // result kinds
   localparam logic KIND_FWD = 1'b0;
   localparam logic KIND_DX  = 1'b1;

   typedef struct packed {
      logic [3:0]         in_port;
      logic               is_indicator;
      logic signed [31:0] in_value;
      logic [63:0]        in_stamp;
      logic [63:0]        in_symbol;
   } req_type;

   typedef struct packed {
      logic               out_kind;
      logic [3:0]         out_port;
      logic signed [31:0] out_value;
      logic [63:0]        out_stamp;
      logic [63:0]        out_symbol;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

>>> design/dxpu_divider.sv
`default_nettype none
module dxpu_divider
   import dxpu_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32,
   localparam int NQ = VW + 1 + FRAC_BITS
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [NQ-1:0]  dividend,
   input  wire logic [VW:0]    divisor,
   output div_stat_type        stat,
   output logic [NQ-1:0]       quotient
);

   localparam int RW = VW + 2;
   localparam int CW = $clog2(NQ + 1);

   logic [RW-1:0] rem_ff, rem_in;
   logic [NQ-1:0] quo_ff, quo_in;
   logic [VW:0]   dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] trial;
   logic          fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff[RW-2:0], quo_ff[NQ-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(NQ);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, dvs_ff}) : trial;
         quo_in = {quo_ff[NQ-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

>>> design/dx_index_pairing_unit.sv
// Directional movement index pairing unit.
// Request channel (req_valid / req_stall / req_data): indicator and other
// words. Response channel (rsp_valid / rsp_stall / rsp_data): forwarded
// words and DX results. A word moves when valid is high and stall is low.
// Configuration channel (csr_valid / csr_ready / csr_index / csr_wdata)
// writes active, plus port select and minus port select; csr_ready is
// always high.
// A request word is taken in one cycle and examined in the next. Forwarded
// words are loaded into the output register from the decision step. A
// pairing word with a nonzero sum runs a restoring divider one quotient
// bit a cycle, VW+1+FRAC_BITS bits (41 at the default build), then scales
// by 100; a zero sum skips the divider. The result is loaded into the
// output register from the final step. Requests are stalled from
// acceptance until the word leaves the decision step or its result is
// loaded into the output register, so one word is in work at a time.
// A result waiting in the output register does not block a new request.
// When the receiver stalls, the output register holds and a finished word
// waits in its last step. Reset clears the held message, the sequencer
// and the output valid, and sets active to 1 and both port selects to -1.
`default_nettype none
module dx_index_pairing_unit
   import dxpu_pkg::*;
#(
   parameter int VALUE_BITS   = VALUE_BITS_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF,
   parameter int SYMBOL_BYTES = SYMBOL_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_wdata
);

   localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int NQ = VW + 1 + FRAC_BITS;
   localparam logic [VW-1:0] CAP_POS = VW'((64'd1 << (VW - 1)) - 64'd1);
   localparam logic [VW-1:0] CAP_NEG = VW'(64'd1 << (VW - 1));
   localparam logic [NQ-1:0] LIM_POS = NQ'(((64'd1 << (VW - 1)) - 64'd1) / 100);
   localparam logic [NQ-1:0] LIM_NEG = NQ'((64'd1 << (VW - 1)) / 100);
   localparam logic [63:0] SYM_MASK = (SYMBOL_BYTES >= 8) ? {64{1'b1}} :
      ((64'd1 << (8 * SYMBOL_BYTES)) - 64'd1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_DIV    = 2'd2;
   localparam logic [1:0] S_FIN    = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        active_ff;
   logic [4:0]  pdi_sel_ff, mdi_sel_ff;
   req_type     item_ff, item_in;
   logic [1:0]  held_side_ff, held_side_in;
   logic [31:0] held_value_ff, held_value_in;
   logic [63:0] held_stamp_ff, held_stamp_in;
   logic [63:0] held_symbol_ff, held_symbol_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;
   logic [63:0] res_stamp_ff, res_stamp_in;
   logic [63:0] res_symbol_ff, res_symbol_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        req_take, out_free, div_start;
   logic [1:0]  side;
   logic signed [VW:0] pv, mv, sum, diff;
   logic [VW:0]   mag_sum, mag_diff;
   logic [NQ-1:0] dividend, quotient;
   div_stat_type  div_stat;
   logic [VW-1:0]   cap, m_val;
   logic [NQ-1:0]   lim;
   logic [VW+6:0]   prod;
   logic signed [VW-1:0] dx_s;

   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // classify the captured word; minus wins when both selects match
   always_comb begin
      if (pdi_sel_ff[4] || mdi_sel_ff[4]) begin
         side = SIDE_NONE;
      end else if ({1'b0, item_ff.in_port} == mdi_sel_ff) begin
         side = SIDE_MINUS;
      end else if ({1'b0, item_ff.in_port} == pdi_sel_ff) begin
         side = SIDE_PLUS;
      end else begin
         side = SIDE_NONE;
      end
   end

   // operands are exact at VW+1 bits
   always_comb begin
      if (side == SIDE_PLUS) begin
         pv = (VW+1)'(signed'(item_ff.in_value[VW-1:0]));
         mv = (VW+1)'(signed'(held_value_ff[VW-1:0]));
      end else begin
         pv = (VW+1)'(signed'(held_value_ff[VW-1:0]));
         mv = (VW+1)'(signed'(item_ff.in_value[VW-1:0]));
      end
      sum      = pv + mv;
      diff     = pv - mv;
      mag_sum  = sum[VW] ? (VW+1)'(-sum) : (VW+1)'(sum);
      mag_diff = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);
      dividend = NQ'(mag_diff) << FRAC_BITS;
   end

   dxpu_divider #(
      .VALUE_BITS (VALUE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (mag_sum),
      .stat     (div_stat),
      .quotient (quotient)
   );

   // scale by 100 and saturate to the value range
   always_comb begin
      cap  = neg_ff ? CAP_NEG : CAP_POS;
      lim  = neg_ff ? LIM_NEG : LIM_POS;
      prod = (VW+7)'(quotient[VW-1:0]) * (VW+7)'(100);
      if (zero_ff) begin
         m_val = '0;
      end else if (quotient > lim) begin
         m_val = cap;
      end else begin
         m_val = prod[VW-1:0];
      end
      dx_s = neg_ff ? signed'(VW'(0) - m_val) : signed'(m_val);
   end

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      held_side_in   = held_side_ff;
      held_value_in  = held_value_ff;
      held_stamp_in  = held_stamp_ff;
      held_symbol_in = held_symbol_ff;
      neg_in         = neg_ff;
      zero_in        = zero_ff;
      res_stamp_in   = res_stamp_ff;
      res_symbol_in  = res_symbol_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      div_start      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               item_in  = req_data;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!active_ff || !item_ff.is_indicator || side == SIDE_NONE) begin
               // forward; wait for the output register
               if (out_free) begin
                  rsp_in.out_kind   = KIND_FWD;
                  rsp_in.out_port   = (active_ff && !item_ff.is_indicator) ?
                                      4'd0 : item_ff.in_port;
                  rsp_in.out_value  = item_ff.in_value;
                  rsp_in.out_stamp  = item_ff.in_stamp;
                  rsp_in.out_symbol = item_ff.in_symbol;
                  rsp_valid_in      = 1'b1;
                  state_in          = S_IDLE;
               end
            end else if (held_side_ff == SIDE_NONE || held_side_ff == side ||
                         item_ff.in_stamp > held_stamp_ff) begin
               held_side_in   = side;
               held_value_in  = item_ff.in_value;
               held_stamp_in  = item_ff.in_stamp;
               held_symbol_in = item_ff.in_symbol;
               state_in       = S_IDLE;
            end else if (held_stamp_ff > item_ff.in_stamp) begin
               state_in = S_IDLE;
            end else begin
               held_side_in  = SIDE_NONE;
               neg_in        = sum[VW];
               zero_in       = sum == '0;
               res_stamp_in  = held_stamp_ff;
               res_symbol_in = ((side == SIDE_PLUS) ? held_symbol_ff :
                                item_ff.in_symbol) & SYM_MASK;
               if (sum == '0) begin
                  state_in = S_FIN;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_in.out_kind   = KIND_DX;
               rsp_in.out_port   = 4'd0;
               rsp_in.out_value  = 32'(dx_s);
               rsp_in.out_stamp  = res_stamp_ff;
               rsp_in.out_symbol = res_symbol_ff;
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_side_ff <= SIDE_NONE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b1;
         pdi_sel_ff   <= 5'h1f;
         mdi_sel_ff   <= 5'h1f;
      end else begin
         state_ff     <= state_in;
         held_side_ff <= held_side_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ACTIVE:  active_ff  <= csr_wdata[0];
               CSR_PDI_SEL: pdi_sel_ff <= csr_wdata;
               CSR_MDI_SEL: mdi_sel_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      item_ff        <= item_in;
      held_value_ff  <= held_value_in;
      held_stamp_ff  <= held_stamp_in;
      held_symbol_ff <= held_symbol_in;
      neg_ff         <= neg_in;
      zero_ff        <= zero_in;
      res_stamp_ff   <= res_stamp_in;
      res_symbol_ff  <= res_symbol_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_to_decide: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_DECIDE)
      else $error("accepted word did not enter the decision step");

   a_div_in_progress: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_stat.busy || div_stat.done)
      else $error("divider idle while sequencer waits on it");

   a_done_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide step");

   a_dx_on_port0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.out_kind == KIND_DX |-> rsp_ff.out_port == 4'd0)
      else $error("DX result on a nonzero port");

   a_side_code: assert property (@(posedge clock) disable iff (reset)
      held_side_ff != 2'd3)
      else $error("held side code out of range");

endmodule
`default_nettype wire
